// ----- design/echo_group_nearest_range_unit_assert.svh -----
// Assertion macros for the checker file of this block.
// Each macro samples on the rising edge of clk and is disabled in reset.
`ifndef ECHO_GROUP_NEAREST_RANGE_UNIT_ASSERT_SVH
`define ECHO_GROUP_NEAREST_RANGE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EGNR_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("egnr assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define EGNR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("egnr assertion failed");

`endif

// ----- design/egnr_pkg.sv -----
package egnr_pkg;

  // Field widths of the beats.
  localparam int TOF_W   = 16;
  localparam int DIR_W   = 2;
  localparam int CONF_W  = 7;
  localparam int SCALE_W = 16;
  localparam int TALLY_W = 7;

  // Channels in one direction group; the confidence divides by it.
  localparam int unsigned CHANNELS_PER_GROUP = 16;

  // Value that marks "no echo" in the running minimum and in the range.
  localparam logic [TOF_W-1:0]   NO_ECHO     = 16'hFFFF;
  localparam logic [TALLY_W-1:0] TALLY_MAX   = 7'd127;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd28773;

  // Range is (tof * scale) >> 24.
  localparam int RANGE_SHIFT = 24;
  localparam int RANGE_PROD_W = TOF_W + SCALE_W;

  // Confidence = tally * 100 / CHANNELS_PER_GROUP, done as a multiply by a
  // rounded-up reciprocal. With tally below 128 and the group at most 64
  // channels, a 16-bit fraction keeps the truncated quotient exact.
  localparam int unsigned CONF_MAX   = 100;
  localparam int          CONF_SHIFT = 16;
  localparam int unsigned CONF_MUL   =
      (CONF_MAX * (2 ** CONF_SHIFT) + CHANNELS_PER_GROUP - 1) / CHANNELS_PER_GROUP;
  localparam int CONF_MUL_W  = $clog2(CONF_MUL + 1);
  localparam int CONF_PROD_W = TALLY_W + CONF_MUL_W;
  localparam int CONF_QUO_W  = CONF_PROD_W - CONF_SHIFT;

  // Configuration port: one 32-bit register per word.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_RANGE_SCALE = 1'b0;

  typedef struct packed {
    logic [TOF_W-1:0] tof_value;
    logic [DIR_W-1:0] group_dir;
    logic             last_channel;
  } in_item_t;

  typedef struct packed {
    logic [TOF_W-1:0]  dist_cm;
    logic [CONF_W-1:0] confidence_pct;
    logic [DIR_W-1:0]  result_dir;
    logic [TOF_W-1:0]  tof_raw;
  } out_item_t;

endpackage

// ----- design/echo_group_nearest_range_unit.sv -----
// Path: a group's last beat is held in the input register, and its result is then
// written to the result register, which drives out_valid.
// Throughput: one input beat per cycle; only a group's last beat produces a result,
// and that beat waits in the input register, holding in_ready low, while the
// result register is full and out_ready is low.
// Reset (rst_n low, synchronous): both stages empty, running minimum 65535,
// echo count 0, range_scale back to 28773.
module echo_group_nearest_range_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  egnr_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output egnr_pkg::out_item_t                  out_data,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [egnr_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [egnr_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [egnr_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);
  import egnr_pkg::*;

  logic                     in_vld_r, in_vld_nxt;
  in_item_t                 in_r;
  logic                     out_vld_r, out_vld_nxt;
  out_item_t                out_r;
  out_item_t                res;
  logic [TOF_W-1:0]         min_r, min_nxt, min_new;
  logic [TALLY_W-1:0]       tally_r, tally_nxt, tally_new;
  logic [SCALE_W-1:0]       scale_r;
  logic                     out_free;
  logic                     adv;
  logic                     in_fire;
  logic                     tof_hit;
  logic                     tof_lower;
  logic                     echo_found;
  logic                     cfg_wr;
  logic                     cfg_sel_scale;
  logic [RANGE_PROD_W-1:0]  prod_min;
  logic [RANGE_PROD_W-1:0]  prod_tof;
  logic [RANGE_PROD_W-1:0]  prod_sel;
  logic [CONF_PROD_W-1:0]   conf_prod;
  logic [CONF_QUO_W-1:0]    conf_quo;
  logic [CONF_W-1:0]        conf_pct;

  // Handshake: the input register moves on unless it holds a last beat
  // and the result register cannot take the result.
  assign out_free = !out_vld_r || out_ready;
  assign adv      = in_vld_r && (!in_r.last_channel || out_free);
  assign in_ready = !in_vld_r || adv;
  assign in_fire  = in_valid && in_ready;

  // Running minimum and echo count with the registered beat folded in.
  assign tof_hit   = in_r.tof_value != '0;
  assign tof_lower = tof_hit && (in_r.tof_value < min_r);
  assign min_new   = tof_lower ? in_r.tof_value : min_r;
  assign tally_new = (tof_hit && tally_r != TALLY_MAX) ? tally_r + 1'b1 : tally_r;

  // Both candidate minima are scaled in parallel; the compare only selects.
  assign prod_min = RANGE_PROD_W'(min_r) * RANGE_PROD_W'(scale_r);
  assign prod_tof = RANGE_PROD_W'(in_r.tof_value) * RANGE_PROD_W'(scale_r);
  assign prod_sel = tof_lower ? prod_tof : prod_min;

  // Confidence through the reciprocal multiply, clamped to 100 percent.
  assign conf_prod = CONF_PROD_W'(tally_new) * CONF_PROD_W'(CONF_MUL);
  assign conf_quo  = conf_prod[CONF_PROD_W-1:CONF_SHIFT];
  assign conf_pct  = (conf_quo > CONF_QUO_W'(CONF_MAX)) ? CONF_W'(CONF_MAX)
                                                        : conf_quo[CONF_W-1:0];

  // Result of the group; a minimum still at 65535 means no usable echo.
  assign echo_found = min_new != NO_ECHO;

  always_comb begin
    res.result_dir = in_r.group_dir;
    if (echo_found) begin
      res.dist_cm        = TOF_W'(prod_sel[RANGE_PROD_W-1:RANGE_SHIFT]);
      res.confidence_pct = conf_pct;
      res.tof_raw        = min_new;
    end else begin
      res.dist_cm        = NO_ECHO;
      res.confidence_pct = '0;
      res.tof_raw        = '0;
    end
  end

  // Next values of the control and running state.
  always_comb begin
    in_vld_nxt  = in_vld_r;
    out_vld_nxt = out_vld_r;
    min_nxt     = min_r;
    tally_nxt   = tally_r;
    if (in_fire) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
    if (adv) begin
      if (in_r.last_channel) begin
        min_nxt     = NO_ECHO;
        tally_nxt   = '0;
        out_vld_nxt = 1'b1;
      end else begin
        min_nxt   = min_new;
        tally_nxt = tally_new;
        if (out_ready) begin
          out_vld_nxt = 1'b0;
        end
      end
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      min_r     <= NO_ECHO;
      tally_r   <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      min_r     <= min_nxt;
      tally_r   <= tally_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_data;
    end
    if (adv && in_r.last_channel) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // Configuration register: range_scale at word 0.
  assign cfg_wr        = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel_scale = cfg_paddr[CFG_ADDR_W-1:2] == REG_RANGE_SCALE;
  assign cfg_pready    = 1'b1;
  assign cfg_prdata    = cfg_sel_scale ? CFG_DATA_W'(scale_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_wr && cfg_sel_scale) begin
      scale_r <= cfg_pwdata[SCALE_W-1:0];
    end
  end

endmodule

// ----- design/egnr_checker.sv -----
`include "echo_group_nearest_range_unit_assert.svh"

// Port-level checks on the result channel.
module egnr_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input egnr_pkg::out_item_t  out_data
);
  import egnr_pkg::*;

  // A stalled result beat stays and keeps its payload.
  `EGNR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // The confidence never exceeds 100 percent.
  `EGNR_ASSERT_NOW(a_conf_max, out_valid, out_data.confidence_pct <= 7'd100)

  // A group with no usable echo reports no raw value and no confidence.
  `EGNR_ASSERT_NOW(a_no_echo, out_valid && out_data.dist_cm == NO_ECHO, out_data.tof_raw == '0 && out_data.confidence_pct == '0)

  // With an echo the scaled range fits in eight bits.
  `EGNR_ASSERT_NOW(a_range_fit, out_valid && out_data.tof_raw != '0, out_data.dist_cm < 16'd256)

endmodule

bind echo_group_nearest_range_unit egnr_checker u_egnr_checker (.*);

// ----- sim/echo_group_nearest_range_unit_test.sv -----
`timescale 1ns / 100ps

module echo_group_nearest_range_unit_test;
  import egnr_pkg::*;

  // Byte address of the range_scale register.
  localparam logic [CFG_ADDR_W-1:0] SCALE_ADDR = {REG_RANGE_SCALE, 2'b00};
  // Slack after the last owed report has come out, before the next phase.
  localparam int SETTLE_CYCLES = 4;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Group state as the block should hold it, plus the current scale.
  logic [TOF_W-1:0]   near_min;
  logic [TALLY_W-1:0] hit_tally;
  logic [SCALE_W-1:0] scale_now;

  // Range reports still owed by the block, oldest first.
  out_item_t pending_ranges[$];

  int unsigned mismatch_count;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;

  echo_group_nearest_range_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("echo_group_nearest_range_unit_test: FAIL");
    $finish;
  end

  // Result side stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_stall_pct);
  end

  // Folds one channel into the group state. Returns 1 with the range report
  // when the beat closes the group.
  function automatic bit fold_channel(input in_item_t beat, output out_item_t res);
    logic [RANGE_PROD_W-1:0] prod;
    int unsigned             pct;
    res = '0;
    if (beat.tof_value != '0) begin
      // A value of 65535 counts as an echo but never wins the minimum.
      if (beat.tof_value < near_min) near_min = beat.tof_value;
      if (hit_tally != TALLY_MAX) hit_tally = hit_tally + 1'b1;
    end
    if (!beat.last_channel) return 1'b0;
    res.result_dir = beat.group_dir;
    if (near_min != NO_ECHO) begin
      prod = near_min * scale_now;
      pct = hit_tally * CONF_MAX / CHANNELS_PER_GROUP;
      if (pct > CONF_MAX) pct = CONF_MAX;
      res.dist_cm        = TOF_W'(prod >> RANGE_SHIFT);
      res.confidence_pct = pct[CONF_W-1:0];
      res.tof_raw        = near_min;
    end else begin
      res.dist_cm        = NO_ECHO;
      res.confidence_pct = '0;
      res.tof_raw        = '0;
    end
    near_min  = NO_ECHO;
    hit_tally = '0;
    return 1'b1;
  endfunction

  function automatic in_item_t mk_beat(input logic [TOF_W-1:0] tof,
                                       input logic [DIR_W-1:0] dir, input logic last);
    in_item_t beat;
    beat.tof_value    = tof;
    beat.group_dir    = dir;
    beat.last_channel = last;
    return beat;
  endfunction

  // Dense values never return zero, so long groups can saturate the count.
  function automatic logic [TOF_W-1:0] pick_tof(input bit dense);
    int unsigned r;
    r = $urandom_range(9);
    if (!dense && r < 2) return '0;
    case (r)
      2: return NO_ECHO;
      3: return TOF_W'($urandom_range(1, 255));
      4: return NO_ECHO - 1'b1;
      default: return TOF_W'($urandom_range(1, 65535));
    endcase
  endfunction

  // Sends one beat, idling first at random, and records what it should cause.
  task automatic send_beat(input in_item_t beat);
    out_item_t res;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (fold_channel(beat, res)) pending_ranges.push_back(res);
  endtask

  // Stops sending and waits until every owed report has come out.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes range_scale through a setup and an access cycle while the block is idle.
  task automatic write_scale(input logic [SCALE_W-1:0] value);
    settle_idle();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= SCALE_ADDR;
    cfg_pwdata  <= {{(CFG_DATA_W-SCALE_W){1'b0}}, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    scale_now = value;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic send_group(input int n, input logic [DIR_W-1:0] dir, input bit mixed,
                            input bit silent, input bit dense);
    in_item_t beat;
    for (int i = 0; i < n; i++) begin
      if (silent) beat.tof_value = $urandom_range(1) ? NO_ECHO : '0;
      else beat.tof_value = pick_tof(dense);
      beat.group_dir    = mixed ? DIR_W'($urandom_range(3)) : dir;
      beat.last_channel = (i == n - 1);
      send_beat(beat);
    end
  endtask

  // Groups that must report no echo at all.
  task automatic test_no_echo_cases();
    send_beat(mk_beat('0, 2'd0, 1'b1));
    send_beat(mk_beat(NO_ECHO, 2'd1, 1'b1));
    send_beat(mk_beat('0, 2'd2, 1'b0));
    send_beat(mk_beat(NO_ECHO, 2'd3, 1'b1));
  endtask

  // Smallest and largest usable values, and a group with mixed directions.
  task automatic test_echo_extremes();
    send_beat(mk_beat(16'd1, 2'd2, 1'b1));
    send_beat(mk_beat(NO_ECHO - 1'b1, 2'd3, 1'b1));
    send_beat(mk_beat(NO_ECHO, 2'd0, 1'b0));
    send_beat(mk_beat(16'd300, 2'd3, 1'b1));
    send_beat(mk_beat(16'd500, 2'd1, 1'b0));
    send_beat(mk_beat('0, 2'd1, 1'b0));
    send_beat(mk_beat(16'd200, 2'd2, 1'b1));
  endtask

  // Largest scale, then scale zero, which must give range 0 with an echo.
  task automatic test_scale_extremes();
    write_scale('1);
    send_beat(mk_beat(NO_ECHO - 1'b1, 2'd1, 1'b1));
    write_scale('0);
    send_beat(mk_beat(16'd40000, 2'd2, 1'b0));
    send_beat(mk_beat('0, 2'd2, 1'b1));
  endtask

  // Mostly well-formed groups with random content; a few long, silent or
  // mixed-direction groups. Optionally pauses once until all reports are in.
  task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                     input logic [SCALE_W-1:0] scale, input int items,
                                     input bit pause_once);
    int  sent;
    int  n;
    int  r;
    bit  paused;
    bit  dense;
    sent   = 0;
    paused = 1'b0;
    in_idle_pct   = idle;
    out_stall_pct = stall;
    write_scale(scale);
    while (sent < items) begin
      r     = $urandom_range(99);
      dense = (r < 4);
      if (dense) n = $urandom_range(17, 160);
      else if (r < 50) n = CHANNELS_PER_GROUP;
      else n = $urandom_range(1, CHANNELS_PER_GROUP);
      send_group(n, DIR_W'($urandom_range(3)), $urandom_range(9) == 0,
                 $urandom_range(19) == 0, dense);
      sent += n;
      if (pause_once && !paused && sent >= items / 2) begin
        settle_idle();
        paused = 1'b1;
      end
    end
    settle_idle();
  endtask

  // Compares each accepted report with the oldest one owed.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_ranges.size() == 0) begin
        $display("%0t: expected no report, got %h", $time, out_data);
        mismatch_count++;
      end else begin
        want = pending_ranges.pop_front();
        if (out_data.dist_cm !== want.dist_cm) begin
          $display("%0t: dist_cm expected %0d, got %0d", $time, want.dist_cm,
                   out_data.dist_cm);
          mismatch_count++;
        end
        if (out_data.confidence_pct !== want.confidence_pct) begin
          $display("%0t: confidence_pct expected %0d, got %0d", $time,
                   want.confidence_pct, out_data.confidence_pct);
          mismatch_count++;
        end
        if (out_data.result_dir !== want.result_dir) begin
          $display("%0t: result_dir expected %0d, got %0d", $time, want.result_dir,
                   out_data.result_dir);
          mismatch_count++;
        end
        if (out_data.tof_raw !== want.tof_raw) begin
          $display("%0t: tof_raw expected %0d, got %0d", $time, want.tof_raw,
                   out_data.tof_raw);
          mismatch_count++;
        end
      end
    end
  end

  // Reset, directed tests, then three random phases with different idling.
  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    out_ready   <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    mismatch_count = 0;
    in_idle_pct    = 17;
    out_stall_pct  = 72;
    near_min  = NO_ECHO;
    hit_tally = '0;
    scale_now = SCALE_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_no_echo_cases();
    test_echo_extremes();
    test_scale_extremes();
    test_random_traffic(17, 72, SCALE_W'($urandom_range(65535)), 350, 1'b1);
    test_random_traffic(72, 17, SCALE_RESET, 350, 1'b0);
    test_random_traffic(0, 0, SCALE_W'($urandom_range(65535)), 350, 1'b0);

    settle_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_ranges.size() == 0) begin
      $display("echo_group_nearest_range_unit_test: PASS");
    end else begin
      $display("echo_group_nearest_range_unit_test: FAIL");
    end
    $finish;
  end

endmodule
